### hdl/rrtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task table package
// Types and constants shared by the controller, the slot cells and the top.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  // Slot numbers inside the cell row are carried at the widest supported
  // table size of 64 slots.
  localparam int SLOT_W = 6;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  // Request codes on the mode field.
  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_KILL    = 3'd1;
  localparam logic [2:0] MODE_SUSPEND = 3'd2;
  localparam logic [2:0] MODE_RESUME  = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;
  localparam logic [2:0] MODE_SWITCH  = 3'd5;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_RUNNING   = 2'd1,
    SLOT_SUSPENDED = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_KILL,
    CELL_SUSPEND,
    CELL_RESUME,
    CELL_CHECK_RUN,
    CELL_CLAIM
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } fsm_state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t    op;
    slot_idx_t   target;
    logic        launch;
    slot_idx_t   launch_at;
    logic        clear;
    slot_state_t seek;
  } cell_cmd_t;

  // Status returned by each cell.
  typedef struct packed {
    logic tok;
    logic hit;
    logic ack;
  } cell_rsp_t;

endpackage : rrtt_pkg
`default_nettype wire

### hdl/rrtt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task table slot cell
// Holds the state of one task slot and one stage of the circulating scan
// token. Addressed commands update the slot in place.
// ----------------------------------------------------------------------------
module rrtt_cell #(
  parameter rrtt_pkg::slot_idx_t CELL_ID = '0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rrtt_pkg::cell_cmd_t cmd,
  input  wire logic                tok_in,
  output rrtt_pkg::cell_rsp_t      rsp
);
  import rrtt_pkg::*;

  slot_state_t slot_q;
  slot_state_t slot_next;
  logic        tok_q;
  logic        tok_next;
  logic        ack;
  logic        addressed;

  assign addressed = (cmd.target == CELL_ID);

  always_comb begin
    ack       = 1'b0;
    slot_next = slot_q;
    if (addressed) begin
      unique case (cmd.op)
        CELL_NOP: begin
        end
        CELL_KILL: begin
          if (slot_q != SLOT_FREE) begin
            ack       = 1'b1;
            slot_next = SLOT_FREE;
          end
        end
        CELL_SUSPEND: begin
          if (slot_q == SLOT_RUNNING) begin
            ack       = 1'b1;
            slot_next = SLOT_SUSPENDED;
          end
        end
        CELL_RESUME: begin
          if (slot_q == SLOT_SUSPENDED) begin
            ack       = 1'b1;
            slot_next = SLOT_RUNNING;
          end
        end
        CELL_CHECK_RUN: begin
          ack = (slot_q == SLOT_RUNNING);
        end
        CELL_CLAIM: begin
          ack       = 1'b1;
          slot_next = SLOT_RUNNING;
        end
        default: begin
        end
      endcase
    end
  end

  // The token enters at the launch slot and then moves one cell per cycle.
  always_comb begin
    if (cmd.launch) begin
      tok_next = (cmd.launch_at == CELL_ID);
    end else if (cmd.clear) begin
      tok_next = 1'b0;
    end else begin
      tok_next = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_q <= (CELL_ID == '0) ? SLOT_RUNNING : SLOT_FREE;
      tok_q  <= 1'b0;
    end else begin
      slot_q <= slot_next;
      tok_q  <= tok_next;
    end
  end

  assign rsp.tok = tok_q;
  assign rsp.hit = tok_q && (slot_q == cmd.seek);
  assign rsp.ack = ack;

endmodule : rrtt_cell
`default_nettype wire

### hdl/rrtt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task table controller
// Sequences one request: issues addressed commands to the cells, launches
// and follows the scan token, and registers the result.
// ----------------------------------------------------------------------------
module rrtt_ctrl #(
  parameter int TASK_COUNT = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [2:0]          mode,
  input  wire logic [3:0]          task_index,
  output logic                     busy,
  output logic                     done,
  output logic                     ok,
  output logic [3:0]               task_slot,
  output logic [3:0]               current_task,
  output logic                     switched,
  output rrtt_pkg::cell_cmd_t      cmd,
  input  wire logic                any_hit,
  input  wire logic                any_ack
);
  import rrtt_pkg::*;

  localparam int CW = $clog2(TASK_COUNT);
  localparam logic [CW-1:0] LAST_SLOT = CW'(TASK_COUNT - 1);
  localparam logic [CW-1:0] SCAN_STEPS = CW'(TASK_COUNT - 2);

  fsm_state_t     state;
  fsm_state_t     state_next;
  logic [2:0]     mode_q;
  logic [3:0]     index_q;
  logic [CW-1:0]  cur;
  logic [CW-1:0]  scan_pos;
  logic [CW-1:0]  left;
  logic [CW-1:0]  launch_pos;
  logic [CW-1:0]  index_cw;
  logic [7:0]     index_wide;
  logic [7:0]     cur_wide;
  logic [7:0]     pos_wide;
  logic           ok_q;
  logic [3:0]     slot_q;
  logic           switched_q;
  logic           scan_mode;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + CW'(1);
  endfunction

  assign index_wide = 8'(index_q);
  assign index_cw   = index_wide[CW-1:0];
  assign cur_wide   = 8'(cur);
  assign pos_wide   = 8'(scan_pos);
  assign scan_mode  = (mode_q == MODE_CREATE) || (mode_q == MODE_TICK);
  assign launch_pos = (mode_q == MODE_CREATE) ? CW'(1) : wrap_inc(cur);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = scan_mode ? ST_SCAN : ST_RESP;
      ST_SCAN: if (any_hit || (left == '0)) state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Cell commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    cmd.op        = CELL_NOP;
    cmd.target    = SLOT_W'(index_q);
    cmd.launch_at = SLOT_W'(launch_pos);
    cmd.seek      = (mode_q == MODE_CREATE) ? SLOT_FREE : SLOT_RUNNING;
    unique case (state)
      ST_EXEC: begin
        case (mode_q)
          MODE_CREATE, MODE_TICK: cmd.launch = 1'b1;
          MODE_KILL:    cmd.op = (index_q != '0) ? CELL_KILL : CELL_NOP;
          MODE_SUSPEND: cmd.op = (index_q != '0) ? CELL_SUSPEND : CELL_NOP;
          MODE_RESUME:  cmd.op = CELL_RESUME;
          MODE_SWITCH:  cmd.op = CELL_CHECK_RUN;
          default:      cmd.op = CELL_NOP;
        endcase
      end
      ST_SCAN: begin
        if (any_hit || (left == '0)) begin
          cmd.clear = 1'b1;
        end
        if (any_hit && (mode_q == MODE_CREATE)) begin
          cmd.op     = CELL_CLAIM;
          cmd.target = SLOT_W'(scan_pos);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_RESP);
  assign ok           = ok_q;
  assign task_slot    = slot_q;
  assign switched     = switched_q;
  assign current_task = cur_wide[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur   <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_EXEC) && (mode_q == MODE_SWITCH) && any_ack) begin
        cur <= index_cw;
      end else if ((state == ST_SCAN) && any_hit && (mode_q == MODE_TICK)) begin
        cur <= scan_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_q  <= mode;
          index_q <= task_index;
        end
      end
      ST_EXEC: begin
        ok_q       <= any_ack;
        slot_q     <= index_q;
        switched_q <= (mode_q == MODE_SWITCH) && any_ack && (index_cw != cur);
        scan_pos   <= launch_pos;
        left       <= SCAN_STEPS;
      end
      ST_SCAN: begin
        if (any_hit) begin
          ok_q       <= 1'b1;
          slot_q     <= pos_wide[3:0];
          switched_q <= (mode_q == MODE_TICK);
        end else if (left == '0) begin
          ok_q       <= (mode_q == MODE_TICK);
          slot_q     <= (mode_q == MODE_TICK) ? cur_wide[3:0] : 4'd0;
          switched_q <= 1'b0;
        end else begin
          scan_pos <= wrap_inc(scan_pos);
          left     <= left - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule : rrtt_ctrl
`default_nettype wire

### hdl/round_robin_task_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task table
// A task table of TASK_COUNT slots kept in a row of cells, with a controller
// that runs create, kill, suspend, resume, timer tick and switch requests.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------
//   request   start / busy         mode, task_index
//   result    done (one cycle)     ok, task_slot, current_task, switched
//
// A request transaction is taken on a rising edge with start high and busy
// low. Kill, suspend, resume, switch and unused modes go from the execute
// state straight to the result state. Create and timer tick walk a token
// around the cell row, one slot per cycle, in a scan state between the two,
// and the scan stops at the first matching slot or after the last slot to visit.
// Each result transaction is shown for exactly one cycle with done high in
// the last busy cycle; the receiver cannot stall it. The block then returns
// to idle, where it can take the next request. Synchronous reset leaves
// slot 0 running, all other slots free and slot 0 current.
//
// Slot 0 is the kernel and cannot be killed or suspended. Slot numbers are
// reported on four bits; a table wider than 16 slots reports them masked.
// ----------------------------------------------------------------------------
module round_robin_task_table_top #(
  parameter int TASK_COUNT = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] mode,
  input  wire logic [3:0] task_index,
  output logic            busy,
  output logic            done,
  output logic            ok,
  output logic [3:0]      task_slot,
  output logic [3:0]      current_task,
  output logic            switched
);
  import rrtt_pkg::*;

  cell_cmd_t             cmd;
  cell_rsp_t             rsp     [TASK_COUNT];
  logic [TASK_COUNT-1:0] tok_vec;
  logic [TASK_COUNT-1:0] hit_vec;
  logic [TASK_COUNT-1:0] ack_vec;

  rrtt_ctrl #(
    .TASK_COUNT (TASK_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .task_index   (task_index),
    .busy         (busy),
    .done         (done),
    .ok           (ok),
    .task_slot    (task_slot),
    .current_task (current_task),
    .switched     (switched),
    .cmd          (cmd),
    .any_hit      (|hit_vec),
    .any_ack      (|ack_vec)
  );

  // The cells form a ring: each one takes the scan token from the cell
  // below it, and the last cell feeds slot 0.
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    rrtt_cell #(
      .CELL_ID (SLOT_W'(i))
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .tok_in (rsp[(i + TASK_COUNT - 1) % TASK_COUNT].tok),
      .rsp    (rsp[i])
    );
    assign tok_vec[i] = rsp[i].tok;
    assign hit_vec[i] = rsp[i].hit;
    assign ack_vec[i] = rsp[i].ack;
  end

  // At most one scan token is in the ring at any time.
  a_one_token : assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  // An addressed command is answered by at most one cell.
  a_one_ack : assert property (@(posedge clk) disable iff (rst) $onehot0(ack_vec))
    else $error("more than one cell acknowledged a command");

  // A result is followed by an idle cycle in which a new request can enter.
  a_done_then_idle : assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after delivering a result");

  // No token survives the end of a request.
  a_no_token_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> (tok_vec == '0))
    else $error("scan token left in the cell row after a result");

endmodule : round_robin_task_table_top
`default_nettype wire

### bench/tb_task_table_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Task table checker package
// Scoreboard for the round-robin task table: it keeps its own copy of the
// slot table and the current slot, predicts each result and checks it.
// ----------------------------------------------------------------------------
package tb_task_table_pkg;
  import rrtt_pkg::*;

  localparam int TABLE_SLOTS = 16;

  // Mode codes that the block must ignore.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic       ok;
    logic [3:0] slot;
    logic [3:0] current;
    logic       switched;
  } task_result_t;

  class task_ledger;
    slot_state_t  slots [TABLE_SLOTS];
    logic [3:0]   current_slot;
    task_result_t expected_q [$];
    int unsigned  mismatches;
    int unsigned  granted;
    int unsigned  refused;
    int unsigned  mode_count [8];

    function new();
      foreach (slots[i]) slots[i] = SLOT_FREE;
      slots[0] = SLOT_RUNNING;
      current_slot = '0;
      mismatches = 0;
      granted = 0;
      refused = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    // Applies one accepted request to the shadow table and queues the result.
    function void note_request(logic [2:0] req_mode, logic [3:0] idx);
      task_result_t res;
      logic [3:0]   prev;
      logic [3:0]   next;
      prev = current_slot;
      res.ok = 1'b0;
      res.slot = idx;
      case (req_mode)
        MODE_CREATE: begin
          res.slot = '0;
          for (int i = 1; i < TABLE_SLOTS; i++) begin
            if (!res.ok && slots[i] == SLOT_FREE) begin
              slots[i] = SLOT_RUNNING;
              res.slot = 4'(i);
              res.ok = 1'b1;
            end
          end
        end
        MODE_KILL: begin
          if (idx != 0 && slots[idx] != SLOT_FREE) begin
            slots[idx] = SLOT_FREE;
            res.ok = 1'b1;
          end
        end
        MODE_SUSPEND: begin
          if (idx != 0 && slots[idx] == SLOT_RUNNING) begin
            slots[idx] = SLOT_SUSPENDED;
            res.ok = 1'b1;
          end
        end
        MODE_RESUME: begin
          if (slots[idx] == SLOT_SUSPENDED) begin
            slots[idx] = SLOT_RUNNING;
            res.ok = 1'b1;
          end
        end
        MODE_TICK: begin
          // The scan gives up when it wraps back to the current slot, even
          // if that slot is no longer running.
          next = current_slot + 4'd1;
          while (slots[next] != SLOT_RUNNING && next != current_slot)
            next = next + 4'd1;
          current_slot = next;
          res.slot = next;
          res.ok = 1'b1;
        end
        MODE_SWITCH: begin
          if (slots[idx] == SLOT_RUNNING) begin
            current_slot = idx;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.current = current_slot;
      res.switched = (current_slot != prev);
      mode_count[req_mode]++;
      if (res.ok) granted++;
      else refused++;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic ok, logic [3:0] slot, logic [3:0] cur,
                               logic sw);
      task_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result ok=%0d slot=%0d current=%0d switched=%0d",
                   ok, slot, cur, sw);
        return;
      end
      exp = expected_q.pop_front();
      if (ok !== exp.ok || slot !== exp.slot || cur !== exp.current ||
          sw !== exp.switched) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result mismatch: expected ok=%0d slot=%0d current=%0d switched=%0d, got ok=%0d slot=%0d current=%0d switched=%0d",
                   exp.ok, exp.slot, exp.current, exp.switched, ok, slot, cur, sw);
      end
    endfunction

    // Random slot in the wanted state, or any slot when none is in it.
    function logic [3:0] pick_slot(slot_state_t want);
      logic [3:0] hits [$];
      foreach (slots[i]) if (slots[i] == want) hits.push_back(4'(i));
      if (hits.size() == 0) return 4'($urandom_range(0, TABLE_SLOTS - 1));
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage : tb_task_table_pkg
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task table testbench
// Drives create, kill, suspend, resume, tick and switch requests through the
// start/busy port and checks every result against a shadow task table, first
// with a directed sequence and then with random traffic at several paces.
// ----------------------------------------------------------------------------
module tb_top;
  import rrtt_pkg::*;
  import tb_task_table_pkg::*;

  localparam int RANDOM_ITEMS  = 700;
  // The limit covers the slowest request, a create or tick whose scan finds
  // no match, and leaves ample room for long sender gaps on top of that.
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * TABLE_SLOTS + 8;

  logic       clk;
  logic       rst;
  logic       start;
  logic [2:0] mode;
  logic [3:0] task_index;
  logic       busy;
  logic       done;
  logic       ok;
  logic [3:0] task_slot;
  logic [3:0] current_task;
  logic       switched;

  task_ledger ledger;
  int         idle_pct;
  int         quiet_cycles;

  round_robin_task_table_top #(
    .TASK_COUNT (TABLE_SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .task_index   (task_index),
    .busy         (busy),
    .done         (done),
    .ok           (ok),
    .task_slot    (task_slot),
    .current_task (current_task),
    .switched     (switched)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results cannot be held off, so every cycle with done high is a result
  // transaction. Outputs are read right after the rising edge, before the
  // block's own nonblocking updates of that edge land.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      ledger.check_result(ok, task_slot, current_task, switched);
  end

  // Watchdog: counts cycles in which neither a request nor a result
  // transaction takes place.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Issues one request transaction. Called at a falling edge; returns at the
  // falling edge after the request was taken. While idle_pct is nonzero the
  // sender drops start for a random number of cycles first. Start may rise
  // while the block is still busy, so the gaps can fall on any cycle of its work.
  task automatic issue_request(input logic [2:0] req_mode, input logic [3:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    mode       <= req_mode;
    task_index <= idx;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    ledger.note_request(req_mode, idx);
    @(negedge clk);
  endtask

  // One random request. Most of the targeted requests aim at a slot in the
  // state that lets them succeed, so tasks get created, parked, revived and
  // scheduled in long chains; the rest hit any slot and are mostly refused.
  task automatic random_request();
    int         roll;
    logic [2:0] req_mode;
    logic [3:0] idx;
    logic       aimed;
    roll  = $urandom_range(0, 99);
    aimed = ($urandom_range(0, 99) < 70);
    idx   = 4'($urandom_range(0, TABLE_SLOTS - 1));
    if (roll < 20) begin
      req_mode = MODE_CREATE;
    end else if (roll < 33) begin
      req_mode = MODE_KILL;
      if (aimed) idx = ledger.pick_slot(($urandom_range(0, 1) != 0) ?
                                        SLOT_RUNNING : SLOT_SUSPENDED);
    end else if (roll < 46) begin
      req_mode = MODE_SUSPEND;
      if (aimed) idx = ledger.pick_slot(SLOT_RUNNING);
    end else if (roll < 59) begin
      req_mode = MODE_RESUME;
      if (aimed) idx = ledger.pick_slot(SLOT_SUSPENDED);
    end else if (roll < 78) begin
      req_mode = MODE_TICK;
    end else if (roll < 95) begin
      req_mode = MODE_SWITCH;
      if (aimed) idx = ledger.pick_slot(SLOT_RUNNING);
    end else begin
      req_mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end
    issue_request(req_mode, idx);
  endtask

  initial begin
    int pace [3];
    ledger       = new();
    rst          = 1'b1;
    start        = 1'b0;
    mode         = MODE_CREATE;
    task_index   = '0;
    idle_pct     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, starting from the reset table (only the kernel runs).
    issue_request(MODE_TICK,    4'd0);   // lone kernel: tick finds nobody else
    issue_request(MODE_SWITCH,  4'd0);   // switch to the current slot
    issue_request(MODE_SWITCH,  4'd3);   // switch to a free slot is refused
    issue_request(MODE_KILL,    4'd0);   // the kernel cannot be killed
    issue_request(MODE_SUSPEND, 4'd0);   // nor suspended
    issue_request(MODE_RESUME,  4'd0);   // resume of a running slot is refused
    issue_request(MODE_CREATE,  4'd15);
    issue_request(MODE_CREATE,  4'd0);
    issue_request(MODE_CREATE,  4'd7);
    issue_request(MODE_SUSPEND, 4'd2);
    issue_request(MODE_SUSPEND, 4'd2);   // already suspended
    issue_request(MODE_SWITCH,  4'd2);   // cannot switch to a suspended task
    issue_request(MODE_RESUME,  4'd2);
    issue_request(MODE_KILL,    4'd9);   // free slot
    issue_request(MODE_TICK,    4'd0);
    issue_request(MODE_KILL,    4'd1);   // kill the current task
    issue_request(MODE_TICK,    4'd0);   // current slot is left behind
    issue_request(MODE_SPARE_LO, 4'd15);
    issue_request(MODE_SPARE_HI, 4'd10);
    issue_request(MODE_SWITCH,  4'd3);
    // Fill the table, then try once more with no free slot left.
    repeat (13) issue_request(MODE_CREATE, 4'($urandom_range(0, TABLE_SLOTS - 1)));
    issue_request(MODE_CREATE,  4'd5);
    issue_request(MODE_KILL,    4'd15);
    issue_request(MODE_SUSPEND, 4'd14);
    issue_request(MODE_SWITCH,  4'd13);
    issue_request(MODE_TICK,    4'd0);   // wraps past the top back to the kernel

    // Random part in three paces: back to back, a sender that holds start low at
    // odds of 61 in a hundred per step, and one at odds of 14. The receiver side
    // has nothing to stall, since results are shown for a single cycle.
    pace[0] = 0;
    pace[1] = 61;
    pace[2] = 14;
    foreach (pace[p]) begin
      idle_pct = pace[p];
      repeat (RANDOM_ITEMS / 3) random_request();
    end
    start <= 1'b0;

    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.outstanding() != 0)
      $display("ERROR: %0d results never arrived", ledger.outstanding());
    $display("Checked %0d requests over three sender paces: %0d took effect, %0d refused.",
             ledger.granted + ledger.refused, ledger.granted, ledger.refused);
    $display({"By mode: create %0d, kill %0d, suspend %0d, resume %0d, ",
              "tick %0d, switch %0d, unused %0d."},
             ledger.mode_count[MODE_CREATE], ledger.mode_count[MODE_KILL],
             ledger.mode_count[MODE_SUSPEND], ledger.mode_count[MODE_RESUME],
             ledger.mode_count[MODE_TICK], ledger.mode_count[MODE_SWITCH],
             ledger.mode_count[MODE_SPARE_LO] + ledger.mode_count[MODE_SPARE_HI]);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", ledger.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_top
`default_nettype wire

### filelist.f
hdl/rrtt_pkg.sv
hdl/rrtt_cell.sv
hdl/rrtt_ctrl.sv
hdl/round_robin_task_table_top.sv
bench/tb_task_table_pkg.sv
bench/tb_top.sv
